// File: src/skyline_rect_page_allocator_unit_assert.svh
// Assertion macros for the skyline page allocator checker.
`ifndef SKYLINE_RECT_PAGE_ALLOCATOR_UNIT_ASSERT_SVH
`define SKYLINE_RECT_PAGE_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SRPA_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SRPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/srpa_pkg.sv
// Shared types and constants of the skyline page allocator.
package srpa_pkg;

  // Field widths fixed by the interface
  localparam int DIM_W      = 10;
  localparam int IDX_OUT_W  = 10;
  localparam int POS_W      = 8;
  localparam int STATUS_W   = 2;
  // Widest page counter supported (1 << 20 pages)
  localparam int PAGE_IDX_W = 20;

  // Command codes
  localparam logic CMD_ALLOC      = 1'b0;
  localparam logic CMD_START_OVER = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CHECK,
    S_BWD,
    S_FWD,
    S_DECIDE,
    S_WRITE,
    S_SWEEP,
    S_FIN
  } state_t;

  // Per-read control that travels with the memory read data
  typedef struct packed {
    logic bwd;        // backward pass: build block suffix maxima
    logic fwd;        // forward pass: block prefix maxima and window test
    logic blk_reset;  // first column of a block in pass direction
    logic win_vld;    // a full window ends at this column
  } scan_ctl_t;

endpackage

// File: src/srpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srpa_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/srpa_scan.sv
// Window-maximum datapath: block suffix/prefix maxima and best-window test.
module srpa_scan #(
  parameter int PAGE_WIDTH  = 256,
  parameter int PAGE_HEIGHT = 256
) (
  input  logic                               clk,
  input  srpa_pkg::scan_ctl_t                ctl,
  input  logic [$clog2(PAGE_WIDTH)-1:0]      idx,
  input  logic [$clog2(PAGE_HEIGHT+1)-1:0]   ht_rd,
  input  logic [$clog2(PAGE_HEIGHT+1)-1:0]   suf_rd,
  input  logic [$clog2(PAGE_HEIGHT+1)-1:0]   best,
  output logic                               suf_we,
  output logic [$clog2(PAGE_WIDTH)-1:0]      suf_addr,
  output logic [$clog2(PAGE_HEIGHT+1)-1:0]   suf_data,
  output logic [$clog2(PAGE_HEIGHT+1)-1:0]   win,
  output logic                               upd
);

  localparam int HW = $clog2(PAGE_HEIGHT + 1);

  logic [HW-1:0] run_max_r;
  logic [HW-1:0] run_max_nxt;
  logic [HW-1:0] cur_max;

  // Running maximum inside the current block, restarted at block edges
  always_comb begin
    if (ctl.blk_reset || (ht_rd > run_max_r)) begin
      cur_max = ht_rd;
    end else begin
      cur_max = run_max_r;
    end
    run_max_nxt = (ctl.bwd || ctl.fwd) ? cur_max : run_max_r;
  end

  always_ff @(posedge clk) begin
    run_max_r <= run_max_nxt;
  end

  // Backward pass stores suffix maxima
  assign suf_we   = ctl.bwd;
  assign suf_addr = idx;
  assign suf_data = cur_max;

  // Window max is suffix of its first column joined with prefix of its last
  assign win = (suf_rd > cur_max) ? suf_rd : cur_max;
  assign upd = ctl.fwd && ctl.win_vld && (win < best);

endmodule

// File: src/skyline_rect_page_allocator_unit.sv
// Skyline bottom-left rectangle allocator over fixed-size atlas pages.
//
// Input channel (in_valid/in_ready) brings a command, a width and a height;
// the result channel (out_valid/out_ready) returns one result per item:
// page index, x, y, a page-opened flag and a status code.
// The skyline heights live in a RAM of PAGE_WIDTH entries; a second RAM
// holds block suffix maxima. An allocate runs a backward pass over all
// columns, a forward window pass and then writes the covered columns;
// when a new page is opened the write becomes a full sweep over all
// PAGE_WIDTH columns. Oversize rectangles skip the passes and go straight
// to the result; start-over clears the skyline with a full sweep. The
// column RAM port reads or writes one column per cycle. One item is in
// work at a time; in_ready rises in the same cycle that the result is
// loaded into the output register. After reset a clearing pass over all
// columns zeroes the skyline; in_ready stays low until it ends. A finished
// result waits in an output register while out_ready is low; the next
// item can be taken meanwhile, and its result holds until the register
// is free.
module skyline_rect_page_allocator_unit #(
  parameter int PAGE_WIDTH  = 256,
  parameter int PAGE_HEIGHT = 256,
  parameter int MAX_PAGES   = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_command,
  input  logic [srpa_pkg::DIM_W-1:0]            in_rect_width,
  input  logic [srpa_pkg::DIM_W-1:0]            in_rect_height,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [srpa_pkg::IDX_OUT_W-1:0]        out_page_index,
  output logic [srpa_pkg::POS_W-1:0]            out_pos_x,
  output logic [srpa_pkg::POS_W-1:0]            out_pos_y,
  output logic                                  out_opened_page,
  output logic [srpa_pkg::STATUS_W-1:0]         out_status
);

  localparam int XW  = $clog2(PAGE_WIDTH);
  localparam int CW  = $clog2(PAGE_WIDTH + 1);
  localparam int HW  = $clog2(PAGE_HEIGHT + 1);
  localparam int SW  = HW + 1;
  localparam int PGW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int PIW = srpa_pkg::PAGE_IDX_W;
  localparam int DW  = srpa_pkg::DIM_W;
  localparam int OIW = srpa_pkg::IDX_OUT_W;
  localparam int PSW = srpa_pkg::POS_W;
  localparam int STW = srpa_pkg::STATUS_W;

  localparam logic [XW-1:0]  LAST_COL  = XW'(PAGE_WIDTH - 1);
  localparam logic [PGW-1:0] LAST_PAGE = PGW'(MAX_PAGES - 1);
  localparam logic [HW-1:0]  FULL_HT   = HW'(PAGE_HEIGHT);

  // Sequencer and item registers
  srpa_pkg::state_t    state_r, state_nxt;
  logic                cmd_r, cmd_nxt;
  logic [DW-1:0]       w_r, w_nxt;
  logic [DW-1:0]       h_r, h_nxt;
  logic [XW-1:0]       j_r, j_nxt;
  logic [XW-1:0]       k_r, k_nxt;
  logic                iss_done_r, iss_done_nxt;
  srpa_pkg::scan_ctl_t p_ctl_r, p_ctl_nxt;
  logic [XW-1:0]       p_idx_r, p_idx_nxt;
  logic                p_last_r, p_last_nxt;
  logic [HW-1:0]       best_r, best_nxt;
  logic [XW-1:0]       bx_r, bx_nxt;
  logic                opened_r, opened_nxt;
  logic [STW-1:0]      status_r, status_nxt;
  logic [PGW-1:0]      cur_page_r, cur_page_nxt;
  logic                page_open_r, page_open_nxt;
  logic [XW-1:0]       wa_r, wa_nxt;
  logic [XW-1:0]       wlast_r, wlast_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic [OIW-1:0]      out_page_r, out_page_nxt;
  logic [PSW-1:0]      out_x_r, out_x_nxt;
  logic [PSW-1:0]      out_y_r, out_y_nxt;
  logic                out_opened_r, out_opened_nxt;
  logic [STW-1:0]      out_status_r, out_status_nxt;

  // Memory ports
  logic                ht_we;
  logic [XW-1:0]       ht_waddr;
  logic [HW-1:0]       ht_wdata;
  logic [XW-1:0]       ht_raddr;
  logic [HW-1:0]       ht_rdata;
  logic                suf_we;
  logic [XW-1:0]       suf_waddr;
  logic [HW-1:0]       suf_wdata;
  logic [XW-1:0]       suf_raddr;
  logic [HW-1:0]       suf_rdata;

  // Scan results
  logic [HW-1:0]       scan_win;
  logic                scan_upd;

  // Derived item values
  logic [CW-1:0]       w_c;
  logic [XW-1:0]       wm1;
  logic [HW-1:0]       h_c;
  logic                too_large;
  logic [SW-1:0]       sum_ht;
  logic                fits;
  logic [HW-1:0]       new_ht;
  logic                out_free;
  logic [PIW-1:0]      page_ext;

  assign w_c       = CW'(w_r);
  assign wm1       = XW'(w_c - 1'b1);
  assign h_c       = HW'(h_r);
  assign too_large = (w_r == '0) || (h_r == '0) ||
                     (int'(w_r) > PAGE_WIDTH) || (int'(h_r) > PAGE_HEIGHT);
  assign sum_ht    = SW'(best_r) + SW'(h_c);
  assign fits      = (sum_ht <= SW'(PAGE_HEIGHT));
  assign new_ht    = HW'(sum_ht);
  assign out_free  = !out_valid_r || out_ready;
  assign page_ext  = PIW'(cur_page_r);

  // Skyline heights, one entry per column
  srpa_ram #(
    .WIDTH (HW),
    .DEPTH (PAGE_WIDTH)
  ) u_ht_ram (
    .clk   (clk),
    .we    (ht_we),
    .waddr (ht_waddr),
    .wdata (ht_wdata),
    .raddr (ht_raddr),
    .rdata (ht_rdata)
  );

  // Block suffix maxima of the current search
  srpa_ram #(
    .WIDTH (HW),
    .DEPTH (PAGE_WIDTH)
  ) u_suf_ram (
    .clk   (clk),
    .we    (suf_we),
    .waddr (suf_waddr),
    .wdata (suf_wdata),
    .raddr (suf_raddr),
    .rdata (suf_rdata)
  );

  srpa_scan #(
    .PAGE_WIDTH  (PAGE_WIDTH),
    .PAGE_HEIGHT (PAGE_HEIGHT)
  ) u_scan (
    .clk      (clk),
    .ctl      (p_ctl_r),
    .idx      (p_idx_r),
    .ht_rd    (ht_rdata),
    .suf_rd   (suf_rdata),
    .best     (best_r),
    .suf_we   (suf_we),
    .suf_addr (suf_waddr),
    .suf_data (suf_wdata),
    .win      (scan_win),
    .upd      (scan_upd)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srpa_pkg::S_INIT: begin
        if (wa_r == LAST_COL) state_nxt = srpa_pkg::S_IDLE;
      end
      srpa_pkg::S_IDLE: begin
        if (in_valid) state_nxt = srpa_pkg::S_CHECK;
      end
      srpa_pkg::S_CHECK: begin
        if (cmd_r == srpa_pkg::CMD_START_OVER) begin
          state_nxt = srpa_pkg::S_SWEEP;
        end else if (too_large) begin
          state_nxt = srpa_pkg::S_FIN;
        end else begin
          state_nxt = srpa_pkg::S_BWD;
        end
      end
      srpa_pkg::S_BWD: begin
        if (p_ctl_r.bwd && p_last_r) state_nxt = srpa_pkg::S_FWD;
      end
      srpa_pkg::S_FWD: begin
        if (p_ctl_r.fwd && p_last_r) state_nxt = srpa_pkg::S_DECIDE;
      end
      srpa_pkg::S_DECIDE: begin
        if (fits) begin
          state_nxt = srpa_pkg::S_WRITE;
        end else if (cur_page_r == LAST_PAGE) begin
          state_nxt = srpa_pkg::S_FIN;
        end else begin
          state_nxt = srpa_pkg::S_SWEEP;
        end
      end
      srpa_pkg::S_WRITE: begin
        if (wa_r == wlast_r) state_nxt = srpa_pkg::S_FIN;
      end
      srpa_pkg::S_SWEEP: begin
        if (wa_r == LAST_COL) state_nxt = srpa_pkg::S_FIN;
      end
      srpa_pkg::S_FIN: begin
        if (out_free) state_nxt = srpa_pkg::S_IDLE;
      end
      default: state_nxt = srpa_pkg::S_INIT;
    endcase
  end

  // Datapath and memory control per state
  always_comb begin
    cmd_nxt        = cmd_r;
    w_nxt          = w_r;
    h_nxt          = h_r;
    j_nxt          = j_r;
    k_nxt          = k_r;
    iss_done_nxt   = iss_done_r;
    p_ctl_nxt      = '0;
    p_idx_nxt      = p_idx_r;
    p_last_nxt     = p_last_r;
    best_nxt       = best_r;
    bx_nxt         = bx_r;
    opened_nxt     = opened_r;
    status_nxt     = status_r;
    cur_page_nxt   = cur_page_r;
    page_open_nxt  = page_open_r;
    wa_nxt         = wa_r;
    wlast_nxt      = wlast_r;
    out_page_nxt   = out_page_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_opened_nxt = out_opened_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    ht_we          = 1'b0;
    ht_waddr       = wa_r;
    ht_wdata       = '0;
    ht_raddr       = j_r;
    suf_raddr      = j_r - wm1;

    case (state_r)
      srpa_pkg::S_INIT: begin
        // Zero the skyline after reset
        ht_we  = 1'b1;
        wa_nxt = wa_r + 1'b1;
      end
      srpa_pkg::S_IDLE: begin
        // Latch the item on transfer
        if (in_valid) begin
          cmd_nxt = in_command;
          w_nxt   = in_rect_width;
          h_nxt   = in_rect_height;
        end
      end
      srpa_pkg::S_CHECK: begin
        if (cmd_r == srpa_pkg::CMD_START_OVER) begin
          // Drop all pages and clear the skyline
          cur_page_nxt  = '0;
          page_open_nxt = 1'b0;
          bx_nxt        = '0;
          best_nxt      = '0;
          opened_nxt    = 1'b0;
          status_nxt    = srpa_pkg::STATUS_OK;
          wa_nxt        = '0;
        end else if (too_large) begin
          bx_nxt     = '0;
          best_nxt   = '0;
          opened_nxt = 1'b0;
          status_nxt = srpa_pkg::STATUS_TOO_LARGE;
        end else begin
          // First allocation opens page 0, whose skyline is already zero
          opened_nxt    = !page_open_r;
          page_open_nxt = 1'b1;
          status_nxt    = srpa_pkg::STATUS_OK;
          best_nxt      = FULL_HT;
          bx_nxt        = '0;
          j_nxt         = LAST_COL;
          k_nxt         = '0;
          iss_done_nxt  = 1'b0;
        end
      end
      srpa_pkg::S_BWD: begin
        // Read columns right to left; blocks of width w end where k is zero
        if (!iss_done_r) begin
          p_ctl_nxt.bwd       = 1'b1;
          p_ctl_nxt.blk_reset = (k_r == '0);
          p_idx_nxt           = j_r;
          p_last_nxt          = (j_r == '0);
          if (j_r == '0) begin
            iss_done_nxt = 1'b1;
          end else begin
            j_nxt = j_r - 1'b1;
            k_nxt = (k_r == wm1) ? '0 : k_r + 1'b1;
          end
        end
        if (p_ctl_r.bwd && p_last_r) begin
          j_nxt        = '0;
          iss_done_nxt = 1'b0;
        end
      end
      srpa_pkg::S_FWD: begin
        // Read columns left to right, the window start from the suffix RAM
        if (!iss_done_r) begin
          p_ctl_nxt.fwd       = 1'b1;
          p_ctl_nxt.blk_reset = (k_r == wm1) || (j_r == '0);
          p_ctl_nxt.win_vld   = (j_r >= wm1);
          p_idx_nxt           = j_r - wm1;
          p_last_nxt          = (j_r == LAST_COL);
          if (j_r == LAST_COL) begin
            iss_done_nxt = 1'b1;
          end else begin
            j_nxt = j_r + 1'b1;
            k_nxt = (k_r == '0) ? wm1 : k_r - 1'b1;
          end
        end
        // Keep the leftmost window with the lowest maximum
        if (scan_upd) begin
          best_nxt = scan_win;
          bx_nxt   = p_idx_r;
        end
      end
      srpa_pkg::S_DECIDE: begin
        if (fits) begin
          wa_nxt    = bx_r;
          wlast_nxt = bx_r + wm1;
        end else if (cur_page_r == LAST_PAGE) begin
          bx_nxt     = '0;
          best_nxt   = '0;
          opened_nxt = 1'b0;
          status_nxt = srpa_pkg::STATUS_EXHAUSTED;
        end else begin
          // Open the next page; the sweep clears it and places at the origin
          cur_page_nxt = cur_page_r + 1'b1;
          opened_nxt   = 1'b1;
          bx_nxt       = '0;
          best_nxt     = '0;
          wa_nxt       = '0;
        end
      end
      srpa_pkg::S_WRITE: begin
        // Raise covered columns
        ht_we    = 1'b1;
        ht_wdata = new_ht;
        wa_nxt   = wa_r + 1'b1;
      end
      srpa_pkg::S_SWEEP: begin
        // Clear the page, writing the new rectangle into its first columns
        ht_we = 1'b1;
        if ((cmd_r == srpa_pkg::CMD_ALLOC) && (CW'(wa_r) < w_c)) begin
          ht_wdata = h_c;
        end
        wa_nxt = wa_r + 1'b1;
      end
      srpa_pkg::S_FIN: begin
        // Hand the result to the output register once it is free
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_page_nxt   = (status_r == srpa_pkg::STATUS_OK) ? page_ext[OIW-1:0] : '0;
          out_x_nxt      = PSW'(bx_r);
          out_y_nxt      = PSW'(best_r);
          out_opened_nxt = opened_r;
          out_status_nxt = status_r;
        end
      end
      default: begin
        ht_we = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srpa_pkg::S_INIT;
      wa_r        <= '0;
      iss_done_r  <= 1'b0;
      p_ctl_r     <= '0;
      cur_page_r  <= '0;
      page_open_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wa_r        <= wa_nxt;
      iss_done_r  <= iss_done_nxt;
      p_ctl_r     <= p_ctl_nxt;
      cur_page_r  <= cur_page_nxt;
      page_open_r <= page_open_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    w_r          <= w_nxt;
    h_r          <= h_nxt;
    j_r          <= j_nxt;
    k_r          <= k_nxt;
    p_idx_r      <= p_idx_nxt;
    p_last_r     <= p_last_nxt;
    best_r       <= best_nxt;
    bx_r         <= bx_nxt;
    opened_r     <= opened_nxt;
    status_r     <= status_nxt;
    wlast_r      <= wlast_nxt;
    out_page_r   <= out_page_nxt;
    out_x_r      <= out_x_nxt;
    out_y_r      <= out_y_nxt;
    out_opened_r <= out_opened_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_ready        = (state_r == srpa_pkg::S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_page_index  = out_page_r;
  assign out_pos_x       = out_x_r;
  assign out_pos_y       = out_y_r;
  assign out_opened_page = out_opened_r;
  assign out_status      = out_status_r;

endmodule

// File: src/srpa_checker.sv
// Port-level checker for the skyline page allocator, bound to the top level.
`include "skyline_rect_page_allocator_unit_assert.svh"

module srpa_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           in_command,
  input logic [srpa_pkg::DIM_W-1:0]     in_rect_width,
  input logic [srpa_pkg::DIM_W-1:0]     in_rect_height,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [srpa_pkg::IDX_OUT_W-1:0] out_page_index,
  input logic [srpa_pkg::POS_W-1:0]     out_pos_x,
  input logic [srpa_pkg::POS_W-1:0]     out_pos_y,
  input logic                           out_opened_page,
  input logic [srpa_pkg::STATUS_W-1:0]  out_status
);

  localparam int IN_PAY_W  = 1 + 2 * srpa_pkg::DIM_W;
  localparam int OUT_PAY_W = srpa_pkg::IDX_OUT_W + 2 * srpa_pkg::POS_W + 1 +
                             srpa_pkg::STATUS_W;

  logic                 in_xfer;
  logic                 in_wait;
  logic                 out_stall;
  logic                 err_res;
  logic                 pay_zero;
  logic                 fresh_page;
  logic                 at_origin;
  logic [IN_PAY_W-1:0]  in_pay;
  logic [OUT_PAY_W-1:0] out_pay;

  assign in_xfer    = in_valid && in_ready;
  assign in_wait    = in_valid && !in_ready;
  assign out_stall  = out_valid && !out_ready;
  assign err_res    = out_valid && (out_status != srpa_pkg::STATUS_OK);
  assign pay_zero   = (out_page_index == '0) && (out_pos_x == '0) &&
                      (out_pos_y == '0) && !out_opened_page;
  assign fresh_page = out_valid && out_opened_page;
  assign at_origin  = (out_pos_x == '0) && (out_pos_y == '0) &&
                      (out_status == srpa_pkg::STATUS_OK);
  assign in_pay     = {in_command, in_rect_width, in_rect_height};
  assign out_pay    = {out_page_index, out_pos_x, out_pos_y, out_opened_page, out_status};

  // Error results carry no placement
  `SRPA_ASSERT_IMPLY(a_err_zero, err_res, pay_zero, "error result with placement data")
  // A rectangle on a freshly opened page sits at the origin
  `SRPA_ASSERT_IMPLY(a_open_origin, fresh_page, at_origin, "new page rect not at origin")
  // One item in work at a time: no second transfer right after one
  `SRPA_ASSERT_NEXT(a_one_item, in_xfer, !in_ready, "input ready right after a transfer")
  // A stalled result holds
  `SRPA_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_pay), "stalled result changed")
  // A waiting input item holds
  `SRPA_ASSERT_NEXT(a_in_hold, in_wait, in_valid && $stable(in_pay), "waiting input changed")

endmodule

bind skyline_rect_page_allocator_unit srpa_checker u_srpa_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_command      (in_command),
  .in_rect_width   (in_rect_width),
  .in_rect_height  (in_rect_height),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_page_index  (out_page_index),
  .out_pos_x       (out_pos_x),
  .out_pos_y       (out_pos_y),
  .out_opened_page (out_opened_page),
  .out_status      (out_status)
);
